// ----- src/lzss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS compressor package
// Shared constants, request types and memory word types of the compressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int WIN_SIZE  = 1024;
  localparam int MAX_MATCH = 66;
  localparam int MIN_CODED = 2;
  localparam int MEM_DEPTH = 2048;

  localparam logic [10:0] NODE_NONE    = 11'(WIN_SIZE);
  localparam logic [10:0] ROOT_BASE    = 11'(WIN_SIZE + 1);
  localparam logic [10:0] MIRROR_BASE  = 11'(WIN_SIZE);
  localparam logic [10:0] CLR_LAST     = 11'(MEM_DEPTH - 1);
  localparam logic [9:0]  CUR_START    = 10'(WIN_SIZE - MAX_MATCH);
  localparam logic [9:0]  MIRROR_LIMIT = 10'(MAX_MATCH - 1);
  localparam logic [6:0]  LEN_FULL     = 7'(MAX_MATCH);
  localparam logic [6:0]  CMP_LAST     = 7'(MAX_MATCH - 1);
  localparam logic [6:0]  LEN_CODED    = 7'(MIN_CODED);
  localparam logic [6:0]  LEN_BIAS     = 7'(MIN_CODED + 1);
  localparam logic [3:0]  UNITS_FULL   = 4'd8;

  typedef logic [10:0] node_t;

  typedef struct packed {
    node_t parent;
    node_t left;
    node_t right;
  } link_t;

  typedef struct packed {
    logic parent;
    logic left;
    logic right;
  } link_we_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } src_t;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    logic [4:0]  payload_count;
    logic        stream_done;
  } grp_t;

  typedef struct packed {
    logic       clear;
    logic       put_lit;
    logic       put_pair;
    logic [7:0] b0;
    logic [7:0] b1;
  } pack_cmd_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [63:0] bytes_lo;
    logic [63:0] bytes_hi;
    logic [4:0]  fill;
    logic        full;
  } pack_grp_t;

endpackage

// ----- src/lzss_tree_compressor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS tree compressor
// Streaming LZSS compressor with a 1024-byte window and binary search trees.
// ----------------------------------------------------------------------------
// One source request is taken at a time. A byte in the stream phase costs one
// tree delete and one tree insert, run by a sequencer against the link memory
// (registered read data). Its cost grows with each tree level the insert
// visits, each level the delete walks to find the successor and each byte
// compared (up to 65), and is larger when the deleted node has two children,
// so the cost of a byte grows with tree depth and match length. The byte that
// first fills the 66-byte lookahead also runs 67 inserts, and the final byte
// drains the lookahead. After reset and after the final group of each stream,
// a clearing pass over all 2048 memory entries zeroes the window and resets
// all links; no request is taken during it. A full group normally moves to the
// output register as soon as that register is free, and the sequencer waits
// until then. While the final byte drains the lookahead, groups queue in a hold
// register ahead of the output register, so there the sequencer stalls only
// when both are occupied.
module lzss_tree_compressor (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  lzss_pkg::src_t   src_data,
  output logic             grp_valid,
  input  logic             grp_ready,
  output lzss_pkg::grp_t   grp_data
);

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    T_LOAD, T_PRE, T_PRE_NX, T_PRE_EM,
    T_SDEL, T_SWR, T_SWR2, T_SADV, T_SEM, T_DONE,
    T_DRAIN, T_DADV, T_END, T_LAST,
    I_RDC, I_INIT, I_RDP, I_STEP, I_ATT, I_CMP0, I_CMP,
    I_R0, I_R1, I_R2, I_R3, I_R4, I_R5, I_R6,
    D_RD, D_CHK, D_QRD, D_QCHK, D_M1, D_M2, D_M3, D_M4, D_M5, D_M6,
    D_FIN, D_PRD, D_PCHK, D_CLR,
    E_0, E_LIT, E_PAIR, E_CHK, F_FLUSH, F_PUSH
  } state_t;

  state_t state;
  state_t ret;

  logic [10:0] clr_cnt;
  logic [7:0]  in_byte;
  logic        last_mode;
  logic [9:0]  wp;
  logic [9:0]  cur;
  logic [6:0]  la;
  logic [9:0]  best_pos;
  logic [6:0]  best_len;
  logic [6:0]  skip;
  logic [6:0]  pre_i;
  logic [6:0]  ci;
  logic        cmp_ge;
  logic        moved;
  lzss_pkg::node_t r;
  lzss_pkg::node_t p;
  lzss_pkg::node_t q;
  lzss_pkg::node_t qp;
  lzss_pkg::node_t ql;
  lzss_pkg::node_t n_par;
  lzss_pkg::node_t n_lft;
  lzss_pkg::node_t n_rgt;
  lzss_pkg::grp_t  hold;
  logic            hold_full;

  logic        win_we;
  logic [10:0] win_waddr;
  logic [7:0]  win_wdata;
  logic [10:0] win_ra;
  logic [10:0] win_rb;
  logic [7:0]  win_qa;
  logic [7:0]  win_qb;

  lzss_pkg::link_we_t lk_we;
  lzss_pkg::node_t    lk_waddr;
  lzss_pkg::link_t    lk_wdata;
  lzss_pkg::node_t    lk_raddr;
  lzss_pkg::link_t    lk_q;

  lzss_pkg::pack_cmd_t pk_cmd;
  lzss_pkg::pack_grp_t pk_grp;

  logic            out_free;
  logic            flush_go;
  logic            grp_load;
  logic [6:0]      bl;
  logic [6:0]      ilen;
  logic            cmp_eq;
  logic [6:0]      la_dec;
  logic [6:0]      la_inc;
  lzss_pkg::grp_t  pk_as_grp;
  lzss_pkg::grp_t  hold_last;

  lzss_win_ram u_win (
    .clk     (clk),
    .we      (win_we),
    .waddr   (win_waddr),
    .wdata   (win_wdata),
    .raddr_a (win_ra),
    .raddr_b (win_rb),
    .rdata_a (win_qa),
    .rdata_b (win_qb)
  );

  lzss_link_ram u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_q)
  );

  lzss_group_pack u_pack (
    .clk (clk),
    .rst (rst),
    .cmd (pk_cmd),
    .grp (pk_grp)
  );

  assign src_ready = (state == S_IDLE);
  assign out_free  = !grp_valid || grp_ready;
  assign flush_go  = (state == F_FLUSH) && (!hold_full || out_free);
  assign grp_load  = (flush_go && hold_full) ||
                     (((state == F_PUSH) || (state == T_LAST)) && out_free);
  assign bl        = (best_len > la) ? la : best_len;
  assign cmp_eq    = (win_qa == win_qb);
  assign ilen      = cmp_eq ? lzss_pkg::LEN_FULL : ci;
  assign la_dec    = (la != 7'd0) ? la - 7'd1 : 7'd0;
  assign la_inc    = la + 7'd1;

  always_comb begin
    pk_as_grp.flag_byte     = pk_grp.flags;
    pk_as_grp.payload_low   = pk_grp.bytes_lo;
    pk_as_grp.payload_high  = pk_grp.bytes_hi;
    pk_as_grp.payload_count = pk_grp.fill;
    pk_as_grp.stream_done   = 1'b0;
  end

  always_comb begin
    hold_last             = hold;
    hold_last.stream_done = 1'b1;
  end

  // Window port control.
  always_comb begin
    win_we    = 1'b0;
    win_waddr = clr_cnt;
    win_wdata = '0;
    win_ra    = r;
    win_rb    = p;
    unique case (state)
      S_CLEAR: begin
        win_we = 1'b1;
      end
      T_LOAD: begin
        win_we    = 1'b1;
        win_waddr = {1'b0, cur} + {4'b0, la};
        win_wdata = in_byte;
      end
      T_SWR: begin
        win_we    = 1'b1;
        win_waddr = {1'b0, wp};
        win_wdata = in_byte;
      end
      T_SWR2: begin
        win_we    = 1'b1;
        win_waddr = {1'b0, wp} + lzss_pkg::MIRROR_BASE;
        win_wdata = in_byte;
      end
      I_CMP0: begin
        win_ra = r + 11'd1;
        win_rb = p + 11'd1;
      end
      I_CMP: begin
        win_ra = r + {4'b0, ci} + 11'd1;
        win_rb = p + {4'b0, ci} + 11'd1;
      end
      E_0: begin
        win_ra = {1'b0, cur};
      end
      default: begin
      end
    endcase
  end

  // Link port control.
  always_comb begin
    lk_we    = '0;
    lk_waddr = p;
    lk_wdata = '{parent: lzss_pkg::NODE_NONE, left: lzss_pkg::NODE_NONE,
                 right: lzss_pkg::NODE_NONE};
    lk_raddr = p;
    unique case (state)
      S_CLEAR: begin
        lk_we    = '{parent: 1'b1, left: 1'b1, right: 1'b1};
        lk_waddr = clr_cnt;
      end
      I_INIT: begin
        lk_we    = '{parent: 1'b0, left: 1'b1, right: 1'b1};
        lk_waddr = r;
      end
      I_STEP: begin
        if (cmp_ge && lk_q.right == lzss_pkg::NODE_NONE) begin
          lk_we.right    = 1'b1;
          lk_wdata.right = r;
        end else if (!cmp_ge && lk_q.left == lzss_pkg::NODE_NONE) begin
          lk_we.left    = 1'b1;
          lk_wdata.left = r;
        end
      end
      I_ATT: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = r;
        lk_wdata.parent = p;
      end
      I_R1: begin
        lk_we    = '{parent: 1'b1, left: 1'b1, right: 1'b1};
        lk_waddr = r;
        lk_wdata = lk_q;
      end
      I_R2: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = n_lft;
        lk_wdata.parent = r;
      end
      I_R3: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = n_rgt;
        lk_wdata.parent = r;
      end
      I_R4: begin
        lk_raddr = n_par;
      end
      I_R5: begin
        lk_waddr = n_par;
        if (lk_q.right == p) begin
          lk_we.right    = 1'b1;
          lk_wdata.right = r;
        end else begin
          lk_we.left    = 1'b1;
          lk_wdata.left = r;
        end
      end
      I_R6, D_CLR: begin
        lk_we.parent = 1'b1;
      end
      D_QRD: begin
        lk_raddr = q;
      end
      D_M1: begin
        lk_we.right    = 1'b1;
        lk_waddr       = qp;
        lk_wdata.right = ql;
      end
      D_M2: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = ql;
        lk_wdata.parent = qp;
      end
      D_M3: begin
        lk_we.left    = 1'b1;
        lk_waddr      = q;
        lk_wdata.left = n_lft;
      end
      D_M4: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = n_lft;
        lk_wdata.parent = q;
      end
      D_M5: begin
        lk_we.right    = 1'b1;
        lk_waddr       = q;
        lk_wdata.right = n_rgt;
      end
      D_M6: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = n_rgt;
        lk_wdata.parent = q;
      end
      D_FIN: begin
        lk_we.parent    = 1'b1;
        lk_waddr        = q;
        lk_wdata.parent = n_par;
      end
      D_PRD: begin
        lk_raddr = n_par;
      end
      D_PCHK: begin
        lk_waddr = n_par;
        if (lk_q.right == p) begin
          lk_we.right    = 1'b1;
          lk_wdata.right = q;
        end else begin
          lk_we.left    = 1'b1;
          lk_wdata.left = q;
        end
      end
      default: begin
      end
    endcase
  end

  // Packer requests.
  always_comb begin
    pk_cmd       = '0;
    pk_cmd.clear = (state == S_CLEAR) || flush_go;
    unique case (state)
      E_LIT: begin
        pk_cmd.put_lit = 1'b1;
        pk_cmd.b0      = win_qa;
      end
      E_PAIR: begin
        pk_cmd.put_pair = 1'b1;
        pk_cmd.b0       = best_pos[7:0];
        pk_cmd.b1       = {best_pos[9:8], 6'(best_len - lzss_pkg::LEN_BIAS)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret       <= S_IDLE;
      clr_cnt   <= '0;
      last_mode <= 1'b0;
      wp        <= '0;
      cur       <= lzss_pkg::CUR_START;
      la        <= '0;
      best_pos  <= '0;
      best_len  <= '0;
      skip      <= '0;
      hold_full <= 1'b0;
      grp_valid <= 1'b0;
    end else begin
      if (grp_load) begin
        grp_valid <= 1'b1;
      end else if (grp_ready) begin
        grp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 11'd1;
          if (clr_cnt == lzss_pkg::CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (src_valid) begin
            in_byte   <= src_data.data_byte;
            last_mode <= src_data.final_byte;
            state     <= (skip == 7'd0) ? T_LOAD : T_SDEL;
          end
        end
        T_LOAD: begin
          la <= la_inc;
          if (la_inc >= lzss_pkg::LEN_FULL || last_mode) begin
            pre_i <= 7'd1;
            state <= T_PRE;
          end else begin
            state <= S_IDLE;
          end
        end
        T_PRE: begin
          r     <= {1'b0, cur} - {4'b0, pre_i};
          ret   <= T_PRE_NX;
          state <= I_RDC;
        end
        T_PRE_NX: begin
          if (pre_i == lzss_pkg::LEN_FULL) begin
            r     <= {1'b0, cur};
            ret   <= T_PRE_EM;
            state <= I_RDC;
          end else begin
            pre_i <= pre_i + 7'd1;
            state <= T_PRE;
          end
        end
        T_PRE_EM: begin
          ret   <= T_DONE;
          state <= E_0;
        end
        T_SDEL: begin
          p     <= {1'b0, wp};
          ret   <= T_SWR;
          state <= D_RD;
        end
        T_SWR: begin
          state <= (wp < lzss_pkg::MIRROR_LIMIT) ? T_SWR2 : T_SADV;
        end
        T_SWR2: begin
          state <= T_SADV;
        end
        T_SADV: begin
          wp    <= wp + 10'd1;
          cur   <= cur + 10'd1;
          r     <= {1'b0, cur + 10'd1};
          skip  <= skip - 7'd1;
          ret   <= T_SEM;
          state <= I_RDC;
        end
        T_SEM: begin
          if (skip == 7'd0) begin
            ret   <= T_DONE;
            state <= E_0;
          end else begin
            state <= T_DONE;
          end
        end
        T_DONE: begin
          state <= last_mode ? T_DRAIN : S_IDLE;
        end
        T_DRAIN: begin
          if (skip != 7'd0) begin
            p     <= {1'b0, wp};
            ret   <= T_DADV;
            state <= D_RD;
          end else if (la == 7'd0) begin
            state <= T_END;
          end else begin
            ret   <= T_DRAIN;
            state <= E_0;
          end
        end
        T_DADV: begin
          wp   <= wp + 10'd1;
          cur  <= cur + 10'd1;
          la   <= la_dec;
          skip <= skip - 7'd1;
          if (la_dec != 7'd0) begin
            r     <= {1'b0, cur + 10'd1};
            ret   <= T_DRAIN;
            state <= I_RDC;
          end else begin
            state <= T_DRAIN;
          end
        end
        T_END: begin
          if (pk_grp.fill != 5'd0) begin
            ret   <= T_LAST;
            state <= F_FLUSH;
          end else begin
            state <= T_LAST;
          end
        end
        T_LAST: begin
          if (out_free) begin
            grp_data  <= hold_last;
            hold_full <= 1'b0;
            last_mode <= 1'b0;
            wp        <= '0;
            cur       <= lzss_pkg::CUR_START;
            la        <= '0;
            best_pos  <= '0;
            best_len  <= '0;
            skip      <= '0;
            clr_cnt   <= '0;
            state     <= S_CLEAR;
          end
        end
        I_RDC: begin
          state <= I_INIT;
        end
        I_INIT: begin
          p        <= lzss_pkg::ROOT_BASE + {3'b0, win_qa};
          best_len <= '0;
          cmp_ge   <= 1'b1;
          state    <= I_RDP;
        end
        I_RDP: begin
          state <= I_STEP;
        end
        I_STEP: begin
          if (cmp_ge) begin
            if (lk_q.right != lzss_pkg::NODE_NONE) begin
              p     <= lk_q.right;
              state <= I_CMP0;
            end else begin
              state <= I_ATT;
            end
          end else begin
            if (lk_q.left != lzss_pkg::NODE_NONE) begin
              p     <= lk_q.left;
              state <= I_CMP0;
            end else begin
              state <= I_ATT;
            end
          end
        end
        I_ATT: begin
          state <= ret;
        end
        I_CMP0: begin
          ci    <= 7'd1;
          state <= I_CMP;
        end
        I_CMP: begin
          if (!cmp_eq || ci == lzss_pkg::CMP_LAST) begin
            cmp_ge <= cmp_eq || (win_qa > win_qb);
            if (ilen > best_len) begin
              best_pos <= p[9:0];
              best_len <= ilen;
              state    <= (ilen >= lzss_pkg::LEN_FULL) ? I_R0 : I_RDP;
            end else begin
              state <= I_RDP;
            end
          end else begin
            ci <= ci + 7'd1;
          end
        end
        I_R0: begin
          state <= I_R1;
        end
        I_R1: begin
          n_par <= lk_q.parent;
          n_lft <= lk_q.left;
          n_rgt <= lk_q.right;
          state <= I_R2;
        end
        I_R2: begin
          state <= I_R3;
        end
        I_R3: begin
          state <= I_R4;
        end
        I_R4: begin
          state <= I_R5;
        end
        I_R5: begin
          state <= I_R6;
        end
        I_R6: begin
          state <= ret;
        end
        D_RD: begin
          state <= D_CHK;
        end
        D_CHK: begin
          n_par <= lk_q.parent;
          n_lft <= lk_q.left;
          n_rgt <= lk_q.right;
          moved <= 1'b0;
          if (lk_q.parent == lzss_pkg::NODE_NONE) begin
            state <= ret;
          end else if (lk_q.right == lzss_pkg::NODE_NONE) begin
            q     <= lk_q.left;
            state <= D_FIN;
          end else if (lk_q.left == lzss_pkg::NODE_NONE) begin
            q     <= lk_q.right;
            state <= D_FIN;
          end else begin
            q     <= lk_q.left;
            state <= D_QRD;
          end
        end
        D_QRD: begin
          state <= D_QCHK;
        end
        D_QCHK: begin
          if (lk_q.right != lzss_pkg::NODE_NONE) begin
            q     <= lk_q.right;
            moved <= 1'b1;
            state <= D_QRD;
          end else begin
            qp    <= lk_q.parent;
            ql    <= lk_q.left;
            state <= moved ? D_M1 : D_M5;
          end
        end
        D_M1: begin
          state <= D_M2;
        end
        D_M2: begin
          state <= D_M3;
        end
        D_M3: begin
          state <= D_M4;
        end
        D_M4: begin
          state <= D_M5;
        end
        D_M5: begin
          state <= D_M6;
        end
        D_M6: begin
          state <= D_FIN;
        end
        D_FIN: begin
          state <= D_PRD;
        end
        D_PRD: begin
          state <= D_PCHK;
        end
        D_PCHK: begin
          state <= D_CLR;
        end
        D_CLR: begin
          state <= ret;
        end
        E_0: begin
          best_len <= bl;
          state    <= (bl <= lzss_pkg::LEN_CODED) ? E_LIT : E_PAIR;
        end
        E_LIT: begin
          best_len <= 7'd1;
          skip     <= 7'd1;
          state    <= E_CHK;
        end
        E_PAIR: begin
          skip  <= best_len;
          state <= E_CHK;
        end
        E_CHK: begin
          state <= pk_grp.full ? F_FLUSH : ret;
        end
        F_FLUSH: begin
          if (flush_go) begin
            if (hold_full) begin
              grp_data <= hold;
            end
            hold      <= pk_as_grp;
            hold_full <= 1'b1;
            state     <= last_mode ? ret : F_PUSH;
          end
        end
        F_PUSH: begin
          if (out_free) begin
            grp_data  <= hold;
            hold_full <= 1'b0;
            state     <= ret;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- src/lzss_win_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window memory
// Byte ring with its mirrored tail, one write port and two registered reads.
// ----------------------------------------------------------------------------
module lzss_win_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [10:0] waddr,
  input  logic [7:0]  wdata,
  input  logic [10:0] raddr_a,
  input  logic [10:0] raddr_b,
  output logic [7:0]  rdata_a,
  output logic [7:0]  rdata_b
);

  logic [7:0] mem [lzss_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/lzss_link_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS tree link memory
// Parent, left and right links of every node and tree root, with per-field
// write enables and one registered read.
// ----------------------------------------------------------------------------
module lzss_link_ram (
  input  logic              clk,
  input  lzss_pkg::link_we_t we,
  input  lzss_pkg::node_t   waddr,
  input  lzss_pkg::link_t   wdata,
  input  lzss_pkg::node_t   raddr,
  output lzss_pkg::link_t   rdata
);

  lzss_pkg::link_t mem [lzss_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we.parent) begin
      mem[waddr].parent <= wdata.parent;
    end
    if (we.left) begin
      mem[waddr].left <= wdata.left;
    end
    if (we.right) begin
      mem[waddr].right <= wdata.right;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lzss_group_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS group packer
// Collects literal and match units into a flag byte and up to 16 payload bytes.
// ----------------------------------------------------------------------------
module lzss_group_pack (
  input  logic                clk,
  input  logic                rst,
  input  lzss_pkg::pack_cmd_t cmd,
  output lzss_pkg::pack_grp_t grp
);

  logic [7:0] bytes [16];
  logic [7:0] flags;
  logic [4:0] fill;
  logic [3:0] units;
  logic [3:0] idx;
  logic [3:0] idx_nx;

  assign idx    = fill[3:0];
  assign idx_nx = idx + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      fill  <= '0;
      units <= '0;
    end else if (cmd.clear) begin
      flags <= '0;
      fill  <= '0;
      units <= '0;
    end else if (cmd.put_lit) begin
      flags[units[2:0]] <= 1'b1;
      fill  <= fill + 5'd1;
      units <= units + 4'd1;
    end else if (cmd.put_pair) begin
      fill  <= fill + 5'd2;
      units <= units + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int j = 0; j < 16; j++) begin
        bytes[j] <= '0;
      end
    end else if (cmd.put_lit) begin
      bytes[idx] <= cmd.b0;
    end else if (cmd.put_pair) begin
      bytes[idx]    <= cmd.b0;
      bytes[idx_nx] <= cmd.b1;
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      grp.bytes_lo[8*j +: 8] = bytes[j];
      grp.bytes_hi[8*j +: 8] = bytes[j + 8];
    end
    grp.flags = flags;
    grp.fill  = fill;
    grp.full  = (units == lzss_pkg::UNITS_FULL);
  end

endmodule

// ----- src/lzss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS compressor port checker
// Checks group framing and both handshakes seen at the top-level ports.
// ----------------------------------------------------------------------------
module lzss_checker (
  input logic           clk,
  input logic           rst,
  input logic           src_valid,
  input logic           src_ready,
  input lzss_pkg::src_t src_data,
  input logic           grp_valid,
  input logic           grp_ready,
  input lzss_pkg::grp_t grp_data
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> (grp_data.payload_count != 5'd0) && (grp_data.payload_count <= 5'd16))
    else $error("group byte count out of range");

  a_full_group: assert property (@(posedge clk) disable iff (rst)
    (grp_valid && !grp_data.stream_done) |->
      (int'(grp_data.payload_count) == 16 - $countones(grp_data.flag_byte)))
    else $error("intermediate group is not a full group of eight units");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (grp_valid && grp_data.payload_count <= 5'd8) |-> (grp_data.payload_high == 64'd0))
    else $error("unused payload bytes are not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (grp_valid && !grp_ready) |=> (grp_valid && $stable(grp_data)))
    else $error("group request changed while stalled");

  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_ready) |=> (src_valid && $stable(src_data)))
    else $error("source request changed while stalled");

endmodule

bind lzss_tree_compressor lzss_checker u_lzss_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_ready (src_ready),
  .src_data  (src_data),
  .grp_valid (grp_valid),
  .grp_ready (grp_ready),
  .grp_data  (grp_data)
);
